### rtl/core/rv32i_instruction_executor_macros.svh
// assertion macros for the rv32i executor checker
`ifndef RV32I_INSTRUCTION_EXECUTOR_MACROS_SVH
`define RV32I_INSTRUCTION_EXECUTOR_MACROS_SVH
// assertion checked on every clock edge outside reset
`define RVX_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`endif

### rtl/core/rvx_pkg.sv
// ----------------------------------------------------------------------------
// rvx_pkg
// shared types and constants of the rv32i executor
// ----------------------------------------------------------------------------
package rvx_pkg;
    localparam int MEM_BYTES = 65536;
    localparam int MEM_WORDS = MEM_BYTES / 4;
    localparam int MA_W = $clog2(MEM_BYTES);
    localparam int WA_W = $clog2(MEM_WORDS);
    localparam int QDEPTH = 2;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_STEP  = 2'd1;
    localparam logic [1:0] ACT_RESET = 2'd2;

    localparam logic [1:0] CAUSE_NONE    = 2'd0;
    localparam logic [1:0] CAUSE_ILLEGAL = 2'd1;
    localparam logic [1:0] CAUSE_CSR     = 2'd2;
    localparam logic [1:0] CAUSE_EBREAK  = 2'd3;

    localparam logic [6:0] OP_LUI = 7'h37, OP_AUIPC = 7'h17, OP_JAL = 7'h6f;
    localparam logic [6:0] OP_JALR = 7'h67, OP_BRANCH = 7'h63, OP_LOAD = 7'h03;
    localparam logic [6:0] OP_STORE = 7'h23, OP_IMM = 7'h13, OP_REG = 7'h33;
    localparam logic [6:0] OP_SYSTEM = 7'h73;
    localparam logic [31:0] EBREAK_ENC = 32'h0010_0073;
    localparam logic [11:0] CSR_MHARTID = 12'hf14;
    localparam logic [31:0] REG_RESET = 32'hf0f0_f0f0;
    localparam logic [7:0] MEM_RESET = 8'ha5;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] load_address;
        logic [31:0] load_word;
    } in_item_t;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        halted;
        logic [1:0]  halt_cause;
        logic [31:0] retired_count;
        logic        reg_write_enable;
        logic [4:0]  reg_write_index;
        logic [31:0] reg_write_value;
        logic        store_enable;
        logic [31:0] store_address;
        logic [31:0] store_value;
    } out_item_t;
endpackage

### rtl/core/rvx_front.sv
// ----------------------------------------------------------------------------
// rvx_front
// accepts requests and queues them for the back end
// ----------------------------------------------------------------------------
module rvx_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  rvx_pkg::in_item_t data_in,
    output logic              q_valid,
    input  logic              q_take,
    output rvx_pkg::in_item_t q_data
);
    import rvx_pkg::*;

    in_item_t  mem_reg [QDEPTH];
    logic      wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic      do_push, do_pop;

    assign full    = (cnt_reg == 2'(QDEPTH));
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data  = mem_reg[rp_reg];
    assign do_push = push && !full;
    assign do_pop  = q_take && q_valid;

    always_comb
    begin
        wp_next  = do_push ? ~wp_reg : wp_reg;
        rp_next  = do_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wp_reg] <= data_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule

### rtl/core/rvx_back.sv
// ----------------------------------------------------------------------------
// rvx_back
// multicycle hart: fetch, execute, load, memory write, with memory clearing pass
// ----------------------------------------------------------------------------
module rvx_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [31:0]        hart_id,
    input  logic               q_valid,
    output logic               q_take,
    input  rvx_pkg::in_item_t  q_data,
    output logic               res_valid,
    input  logic               res_take,
    output rvx_pkg::out_item_t res_data
);
    import rvx_pkg::*;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001, S_IDLE = 7'b0000010, S_FETCH = 7'b0000100,
        S_EXEC = 7'b0001000, S_LOAD = 7'b0010000, S_MEMW = 7'b0100000,
        S_OUT = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    // four byte lanes, one per byte of a word
    logic [7:0] lane0 [MEM_WORDS];
    logic [7:0] lane1 [MEM_WORDS];
    logic [7:0] lane2 [MEM_WORDS];
    logic [7:0] lane3 [MEM_WORDS];
    logic [7:0] rdat [4];
    logic [WA_W:0] clr_reg;
    logic [31:0] rf [32];
    logic [31:0] pc_reg, cnt_reg, insn_reg, a_reg, b_reg;
    logic halt_reg;
    logic [1:0] code_reg;
    logic [31:0] addr_reg, wdata_reg;
    logic [3:0] wmask_reg;
    logic [4:0] rd_reg;
    logic [2:0] f3_reg;
    out_item_t res_reg;
    // output register, lets the core go on while a result waits
    out_item_t out_reg, out_next;
    logic res_v_reg;
    logic out_free;

    // memory port signals
    logic [WA_W-1:0] ra [4];
    logic [WA_W-1:0] wa [4];
    logic [7:0] wd [4];
    logic we [4];
    logic [31:0] rbase;

    assign q_take = (state_reg == S_IDLE) && q_valid;
    assign res_valid = res_v_reg;
    assign res_data = out_reg;
    assign out_free = !res_v_reg || res_take;

    always_comb
    begin
        out_next = res_reg;
        out_next.next_pc = pc_reg;
        out_next.halted = halt_reg;
        out_next.halt_cause = code_reg;
        out_next.retired_count = cnt_reg;
    end

    // decode fields
    logic [6:0] op;
    logic [4:0] rd, rs1, rs2;
    logic [2:0] f3;
    logic [6:0] f7;
    logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j, av, bv;
    assign op = insn_reg[6:0];
    assign rd = insn_reg[11:7];
    assign f3 = insn_reg[14:12];
    assign rs1 = insn_reg[19:15];
    assign rs2 = insn_reg[24:20];
    assign f7 = insn_reg[31:25];
    assign imm_i = {{20{insn_reg[31]}}, insn_reg[31:20]};
    assign imm_s = {{20{insn_reg[31]}}, insn_reg[31:25], insn_reg[11:7]};
    assign imm_b = {{19{insn_reg[31]}}, insn_reg[31], insn_reg[7], insn_reg[30:25],
                    insn_reg[11:8], 1'b0};
    assign imm_u = {insn_reg[31:12], 12'd0};
    assign imm_j = {{11{insn_reg[31]}}, insn_reg[31], insn_reg[19:12], insn_reg[20],
                    insn_reg[30:21], 1'b0};
    assign av = a_reg;
    assign bv = b_reg;

    // execute
    logic [1:0] cause;
    logic wr, take, is_load, is_store;
    logic [31:0] val, nxt, ea, sval;
    logic [3:0] smask;
    logic lt_ab, ltu_ab;
    logic [31:0] opb;
    logic [4:0] sh;

    always_comb
    begin
        cause = CAUSE_NONE;
        wr = 1'b0;
        take = 1'b0;
        is_load = 1'b0;
        is_store = 1'b0;
        val = 32'd0;
        nxt = pc_reg + 32'd4;
        ea = 32'd0;
        sval = 32'd0;
        smask = 4'd0;
        opb = (op == OP_REG) ? bv : imm_i;
        sh = (op == OP_REG) ? bv[4:0] : rs2;
        lt_ab = $signed(av) < $signed(opb);
        ltu_ab = av < opb;
        case (op)
            OP_LUI:   begin wr = 1'b1; val = imm_u; end
            OP_AUIPC: begin wr = 1'b1; val = pc_reg + imm_u; end
            OP_JAL:
            begin
                wr = 1'b1; val = pc_reg + 32'd4; nxt = pc_reg + imm_j;
            end
            OP_JALR:
            begin
                if (f3 != 3'd0) cause = CAUSE_ILLEGAL;
                else
                begin
                    wr = 1'b1; val = pc_reg + 32'd4;
                    nxt = (av + imm_i) & ~32'd1;
                end
            end
            OP_BRANCH:
            begin
                case (f3)
                    3'd0: take = (av == bv);
                    3'd1: take = (av != bv);
                    3'd4: take = $signed(av) < $signed(bv);
                    3'd5: take = !($signed(av) < $signed(bv));
                    3'd6: take = av < bv;
                    3'd7: take = !(av < bv);
                    default: cause = CAUSE_ILLEGAL;
                endcase
                if (take) nxt = pc_reg + imm_b;
            end
            OP_LOAD:
            begin
                ea = av + imm_i;
                if (f3 inside {3'd3, 3'd6, 3'd7}) cause = CAUSE_ILLEGAL;
                else is_load = 1'b1;
            end
            OP_STORE:
            begin
                ea = av + imm_s;
                case (f3)
                    3'd0: begin sval = {24'd0, bv[7:0]}; smask = 4'b0001; end
                    3'd1: begin sval = {16'd0, bv[15:0]}; smask = 4'b0011; end
                    3'd2: begin sval = bv; smask = 4'b1111; end
                    default: cause = CAUSE_ILLEGAL;
                endcase
                is_store = (cause == CAUSE_NONE);
            end
            OP_IMM, OP_REG:
            begin
                wr = 1'b1;
                if (op == OP_REG && !(f7 == 7'd0 || (f7 == 7'h20 &&
                    (f3 == 3'd0 || f3 == 3'd5))))
                    cause = CAUSE_ILLEGAL;
                else if (op == OP_IMM && f3 == 3'd1 && f7 != 7'd0)
                    cause = CAUSE_ILLEGAL;
                else if (op == OP_IMM && f3 == 3'd5 && f7 != 7'd0 && f7 != 7'h20)
                    cause = CAUSE_ILLEGAL;
                case (f3)
                    3'd0: val = (op == OP_REG && f7 == 7'h20) ? av - opb : av + opb;
                    3'd1: val = av << sh;
                    3'd2: val = {31'd0, lt_ab};
                    3'd3: val = {31'd0, ltu_ab};
                    3'd4: val = av ^ opb;
                    3'd5: val = f7[5] ? 32'($signed(av) >>> sh) : av >> sh;
                    3'd6: val = av | opb;
                    default: val = av & opb;
                endcase
            end
            OP_SYSTEM:
            begin
                if (insn_reg == EBREAK_ENC) cause = CAUSE_EBREAK;
                else if (f3 != 3'd2) cause = CAUSE_ILLEGAL;
                else if (insn_reg[31:20] != CSR_MHARTID || rs1 != 5'd0) cause = CAUSE_CSR;
                else begin wr = 1'b1; val = hart_id; end
            end
            default: cause = CAUSE_ILLEGAL;
        endcase
        if (cause != CAUSE_NONE)
        begin
            wr = 1'b0;
            is_load = 1'b0;
            is_store = 1'b0;
        end
    end

    // load data assembly from the four lanes, byte i at rbase+i
    logic [31:0] ldw, lval;
    logic [1:0] boff;
    always_comb
    begin
        boff = addr_reg[1:0];
        for (int i = 0; i < 4; i++)
        begin
            ldw[8*i +: 8] = rdat[2'(boff + 2'(i))];
        end
        case (f3_reg)
            3'd0: lval = {{24{ldw[7]}}, ldw[7:0]};
            3'd1: lval = {{16{ldw[15]}}, ldw[15:0]};
            3'd4: lval = {24'd0, ldw[7:0]};
            3'd5: lval = {16'd0, ldw[15:0]};
            default: lval = ldw;
        endcase
    end

    // read addresses: lane k holds byte at word*4+k
    logic [MA_W-1:0] rbyte;
    always_comb
    begin
        rbase = (state_reg == S_IDLE) ? pc_reg : ea;
        rbyte = rbase[MA_W-1:0];
        for (int k = 0; k < 4; k++)
        begin
            ra[k] = (2'(k) >= rbyte[1:0]) ? rbyte[MA_W-1:2] : WA_W'(rbyte[MA_W-1:2] + 1'b1);
        end
    end

    // write addresses, byte data, enables
    logic [MA_W-1:0] wbyte;
    logic [1:0] j;
    always_comb
    begin
        wbyte = addr_reg[MA_W-1:0];
        for (int k = 0; k < 4; k++)
        begin
            j = 2'(2'(k) - wbyte[1:0]);
            wa[k] = (2'(k) >= wbyte[1:0]) ? wbyte[MA_W-1:2] : WA_W'(wbyte[MA_W-1:2] + 1'b1);
            wd[k] = wdata_reg[8*j +: 8];
            we[k] = (state_reg == S_MEMW) && wmask_reg[j];
            if (state_reg == S_CLEAR)
            begin
                wa[k] = clr_reg[WA_W-1:0];
                wd[k] = MEM_RESET;
                we[k] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we[0]) lane0[wa[0]] <= wd[0];
        if (we[1]) lane1[wa[1]] <= wd[1];
        if (we[2]) lane2[wa[2]] <= wd[2];
        if (we[3]) lane3[wa[3]] <= wd[3];
        rdat[0] <= lane0[ra[0]];
        rdat[1] <= lane1[ra[1]];
        rdat[2] <= lane2[ra[2]];
        rdat[3] <= lane3[ra[3]];
    end

    // fetched word, available in S_FETCH (pc aligned offset)
    logic [31:0] fword;
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            fword[8*i +: 8] = rdat[2'(pc_reg[1:0] + 2'(i))];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: if (clr_reg == (WA_W+1)'(MEM_WORDS - 1)) state_next = S_IDLE;
            S_IDLE:
            begin
                if (q_take)
                begin
                    if (q_data.action == ACT_STEP && !halt_reg) state_next = S_FETCH;
                    else if (q_data.action == ACT_WRITE) state_next = S_MEMW;
                    else state_next = S_OUT;
                end
            end
            S_FETCH: state_next = S_EXEC;
            S_EXEC:  state_next = is_load ? S_LOAD : (is_store ? S_MEMW : S_OUT);
            S_LOAD:  state_next = S_OUT;
            S_MEMW:  state_next = S_OUT;
            // wait here while the output register is still held
            S_OUT:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                addr_reg <= {16'd0, q_data.load_address};
                wdata_reg <= q_data.load_word;
                wmask_reg <= 4'b1111;
            end
            S_FETCH:
            begin
                insn_reg <= fword;
                a_reg <= (fword[19:15] == 5'd0) ? 32'd0 : rf[fword[19:15]];
                b_reg <= (fword[24:20] == 5'd0) ? 32'd0 : rf[fword[24:20]];
            end
            S_EXEC:
            begin
                addr_reg <= ea;
                wdata_reg <= sval;
                wmask_reg <= smask;
                rd_reg <= rd;
                f3_reg <= f3;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            pc_reg <= 32'd0;
            cnt_reg <= 32'd0;
            halt_reg <= 1'b0;
            code_reg <= CAUSE_NONE;
            res_v_reg <= 1'b0;
            res_reg <= '0;
            out_reg <= '0;
            for (int i = 0; i < 32; i++) rf[i] <= (i == 0) ? 32'd0 : REG_RESET;
        end
        else
        begin
            state_reg <= state_next;
            res_v_reg <= ((state_reg == S_OUT) && out_free) || (res_v_reg && !res_take);
            case (state_reg)
                S_CLEAR: clr_reg <= clr_reg + 1'b1;
                S_IDLE:
                begin
                    if (q_take)
                    begin
                        res_reg <= '0;
                        if (q_data.action == ACT_RESET)
                        begin
                            pc_reg <= 32'd0;
                            cnt_reg <= 32'd0;
                            halt_reg <= 1'b0;
                            code_reg <= CAUSE_NONE;
                            for (int i = 1; i < 32; i++) rf[i] <= REG_RESET;
                        end
                    end
                end
                S_FETCH: cnt_reg <= cnt_reg + 32'd1;
                S_EXEC:
                begin
                    if (cause != CAUSE_NONE)
                    begin
                        halt_reg <= 1'b1;
                        code_reg <= cause;
                    end
                    else
                    begin
                        pc_reg <= nxt;
                        if (wr && !is_load && rd != 5'd0)
                        begin
                            rf[rd] <= val;
                            res_reg.reg_write_enable <= 1'b1;
                            res_reg.reg_write_index <= rd;
                            res_reg.reg_write_value <= val;
                        end
                        if (is_store)
                        begin
                            res_reg.store_enable <= 1'b1;
                            res_reg.store_address <= ea;
                            res_reg.store_value <= sval;
                        end
                    end
                end
                S_LOAD:
                begin
                    if (rd_reg != 5'd0)
                    begin
                        rf[rd_reg] <= lval;
                        res_reg.reg_write_enable <= 1'b1;
                        res_reg.reg_write_index <= rd_reg;
                        res_reg.reg_write_value <= lval;
                    end
                end
                S_OUT:
                begin
                    if (out_free) out_reg <= out_next;
                end
                default: ;
            endcase
        end
    end
endmodule

### rtl/core/rv32i_instruction_executor.sv
// ----------------------------------------------------------------------------
// rv32i_instruction_executor
// single-hart rv32i core driven by a request queue
// ----------------------------------------------------------------------------
// channel   | handshake        | payload
// input     | push / full      | data_in  (in_item_t)
// result    | pop / empty      | data_out (out_item_t)
// config    | hart_id_we       | hart_id_wdata
//
// a step passes take and fetch read, register read, execute and output;
// loads and stores add a load or memory-write state; memory-word writes pass
// take, memory write and output; resets, halted steps and unknown requests
// pass take and output. after reset a clearing pass fills memory; no request
// is taken meanwhile. a two-entry queue buffers requests; an output register
// holds one result, and the core waits in its output state while it is full.
module rv32i_instruction_executor (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  rvx_pkg::in_item_t  data_in,
    output logic               empty,
    input  logic               pop,
    output rvx_pkg::out_item_t data_out,
    input  logic               hart_id_we,
    input  logic [31:0]        hart_id_wdata
);
    import rvx_pkg::*;

    logic [31:0] hart_id_reg;
    logic q_valid, q_take, res_valid;
    in_item_t q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) hart_id_reg <= 32'd0;
        else if (hart_id_we) hart_id_reg <= hart_id_wdata;
    end

    rvx_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .data_in(data_in),
        .q_valid(q_valid), .q_take(q_take), .q_data(q_data)
    );

    rvx_back u_back (
        .clk(clk), .rst_n(rst_n), .hart_id(hart_id_reg), .q_valid(q_valid),
        .q_take(q_take), .q_data(q_data), .res_valid(res_valid),
        .res_take(pop && res_valid), .res_data(data_out)
    );

    assign empty = !res_valid;
endmodule

### rtl/core/rvx_checker.sv
// ----------------------------------------------------------------------------
// rvx_checker
// port-level checks of the rv32i executor
// ----------------------------------------------------------------------------
`include "rv32i_instruction_executor_macros.svh"
module rvx_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               empty,
    input logic               pop,
    input rvx_pkg::out_item_t data_out
);
    import rvx_pkg::*;
    `RVX_ASSERT(a_hold, empty == 1'b0 && !pop |=> $stable(data_out))
    `RVX_ASSERT(a_nocause, !data_out.halted || empty |-> data_out.halt_cause == CAUSE_NONE || data_out.halted)
    `RVX_ASSERT(a_x0, empty == 1'b0 && data_out.reg_write_enable |-> data_out.reg_write_index != 5'd0)
endmodule

bind rv32i_instruction_executor rvx_checker u_chk (
    .clk(clk), .rst_n(rst_n), .empty(empty), .pop(pop), .data_out(data_out)
);
